[rtl/epid_pkg.sv]
// Shared types, constants and helpers for the encoder speed PID controller.
// Used by every module under rtl/; depends on nothing else.
`default_nettype none

package epid_pkg;

	// Default width of the quadrature counter being extended
	localparam int COUNTER_BITS_DEF = 16;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 2'd2;

	// Register reset values, signed Q8.8
	localparam logic signed [15:0] GAIN_PROP_RST  = 16'sd512;
	localparam logic signed [15:0] GAIN_INTEG_RST = 16'sd0;
	localparam logic signed [15:0] GAIN_DERIV_RST = 16'sd0;

	// Saturation bounds, on the widest internal sum
	localparam int SUM_W = 43;
	localparam logic signed [SUM_W-1:0] SUM_MAX32 = 43'sd2147483647;
	localparam logic signed [SUM_W-1:0] SUM_MIN32 = -43'sd2147483648;
	localparam logic signed [31:0] INT32_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] INT32_MIN = 32'sh80000000;

	// Error stage result: saturated error, error delta, reported speed
	typedef struct packed {
		logic signed [31:0] err;
		logic signed [32:0] diff;
		logic signed [15:0] speed;
	} epid_err_t;

	// Product stage result: gain products already shifted back to Q.8
	typedef struct packed {
		logic signed [39:0] p;
		logic signed [39:0] ki;
		logic signed [40:0] d;
		logic signed [15:0] speed;
	} epid_prod_t;

	// Clamp a wide signed sum to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] x);
		logic signed [31:0] r;
		if (x > SUM_MAX32) begin
			r = INT32_MAX;
		end else if (x < SUM_MIN32) begin
			r = INT32_MIN;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/epid_speed.sv]
// Input register, counter wrap handling, speed and error computation.
// Depends on epid_pkg (sat32, epid_err_t).
`default_nettype none

module epid_speed import epid_pkg::*; #(
	parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [15:0]        raw_count,
	input  wire logic signed [23:0] speed_target,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output epid_err_t               out_item
);

	localparam int CB = COUNTER_BITS;
	localparam int EW = (CB + 10 > 33) ? CB + 10 : 33;
	localparam int SW = (CB + 1 > 17) ? CB + 1 : 17;
	localparam logic signed [CB+1:0] HALF = (CB + 2)'(1) <<< (CB - 1);
	localparam logic signed [CB+1:0] FULL = (CB + 2)'(1) <<< CB;
	localparam logic signed [SW-1:0] SPD_MAX = SW'(32767);
	localparam logic signed [SW-1:0] SPD_MIN = -(SW'(32768));

	logic                    v_s1, v_s2, adv_s2;
	logic [15:0]             raw_s1;
	logic signed [23:0]      tgt_s1;
	logic [CB-1:0]           last_raw_q;
	logic signed [31:0]      last_error_q;
	logic [CB+15:0]          raw_wide;
	logic [CB-1:0]           raw_c;
	logic signed [CB+1:0]    jump, spd_w;
	logic signed [CB:0]      spd;
	logic signed [EW-1:0]    err_full;
	logic signed [31:0]      err32;
	logic signed [SW-1:0]    spd_x;
	logic signed [15:0]      spd16;
	epid_err_t               item_s2;

	assign adv_s2   = !v_s2 || out_ready;
	assign in_ready = !v_s1 || adv_s2;

	// Mask the counter to its configured width
	assign raw_wide = {CB'(0), raw_s1};
	assign raw_c    = raw_wide[CB-1:0];

	// Extend position: a jump of half the range or more is a wrap
	always_comb begin
		jump = $signed({2'b00, raw_c}) - $signed({2'b00, last_raw_q});
		if (jump >= HALF) begin
			spd_w = jump - FULL;
		end else if (jump <= -HALF) begin
			spd_w = jump + FULL;
		end else begin
			spd_w = jump;
		end
		spd = $signed(spd_w[CB:0]);
	end

	// Error in Q.8, saturated
	assign err_full = EW'(tgt_s1) - (EW'(spd) <<< 8);
	assign err32    = sat32(SUM_W'(err_full));

	// Clamp reported speed to the 16-bit field
	always_comb begin
		spd_x = SW'(spd);
		if (spd_x > SPD_MAX) begin
			spd16 = SPD_MAX[15:0];
		end else if (spd_x < SPD_MIN) begin
			spd16 = SPD_MIN[15:0];
		end else begin
			spd16 = spd_x[15:0];
		end
	end

	// Stage valids and per-item state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			last_raw_q   <= '0;
			last_error_q <= '0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_s2 && v_s1) begin
				last_raw_q   <= raw_c;
				last_error_q <= err32;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			raw_s1 <= raw_count;
			tgt_s1 <= speed_target;
		end
		if (adv_s2 && v_s1) begin
			item_s2.err   <= err32;
			item_s2.diff  <= 33'(err32) - 33'(last_error_q);
			item_s2.speed <= spd16;
		end
	end

	assign out_valid = v_s2;
	assign out_item  = item_s2;

endmodule

`default_nettype wire

[rtl/epid_mult.sv]
// Gain multiplier stage: P, I and D products, shifted back to Q.8 and registered.
// Depends on epid_pkg (epid_err_t, epid_prod_t).
`default_nettype none

module epid_mult import epid_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic signed [15:0] gain_prop,
	input  wire logic signed [15:0] gain_integ,
	input  wire logic signed [15:0] gain_deriv,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire epid_err_t          in_item,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output epid_prod_t              out_item
);

	logic               v_s3;
	logic signed [31:0] err;
	logic signed [32:0] diff;
	logic signed [47:0] prod_p, prod_i;
	logic signed [48:0] prod_d;
	epid_prod_t         item_s3;

	assign in_ready = !v_s3 || out_ready;

	// Signed products; floor shift by 8 is a bit select
	assign err    = in_item.err;
	assign diff   = in_item.diff;
	assign prod_p = gain_prop * err;
	assign prod_i = gain_integ * err;
	assign prod_d = gain_deriv * diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (in_ready) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s3.p     <= prod_p[47:8];
			item_s3.ki    <= prod_i[47:8];
			item_s3.d     <= prod_d[48:8];
			item_s3.speed <= in_item.speed;
		end
	end

	assign out_valid = v_s3;
	assign out_item  = item_s3;

endmodule

`default_nettype wire

[rtl/epid_accum.sv]
// Integrator update, drive sum with saturation, and the output register.
// Depends on epid_pkg (sat32, epid_prod_t).
`default_nettype none

module epid_accum import epid_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire epid_prod_t    in_item,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic signed [31:0] drive,
	output logic signed [15:0] speed
);

	logic                    out_valid_q;
	logic signed [31:0]      integ_q, integ_new, drive_q;
	logic signed [15:0]      speed_q;
	logic signed [40:0]      integ_sum;
	logic signed [SUM_W-1:0] drive_sum;
	logic signed [39:0]      p_term, ki_term;
	logic signed [40:0]      d_term;

	assign in_ready = !out_valid_q || out_ready;

	assign p_term  = in_item.p;
	assign ki_term = in_item.ki;
	assign d_term  = in_item.d;

	// Integrate, then sum the three terms
	assign integ_sum = 41'(integ_q) + 41'(ki_term);
	assign integ_new = sat32(SUM_W'(integ_sum));
	assign drive_sum = SUM_W'(p_term) + SUM_W'(integ_new) + SUM_W'(d_term);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			integ_q     <= '0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
			if (in_valid) begin
				integ_q <= integ_new;
			end
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			drive_q <= sat32(drive_sum);
			speed_q <= in_item.speed;
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign speed     = speed_q;

endmodule

`default_nettype wire

[rtl/encoder_speed_pid_unit.sv]
// Encoder speed PID controller: counter extension, speed, error, P/I/D drive.
// Throughput: one item per cycle while the output is taken; four register
// stages (input, error, products, output) with a ready chain, so no bubble
// while the output waits.
// Reset (arst_n low, asynchronous): pipeline empty, gains 2.0/0/0, last count,
// last error and integrator cleared. Depends on epid_pkg and the epid_* modules.
`default_nettype none

module encoder_speed_pid_unit import epid_pkg::*; #(
	parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [39:0]          s_tdata,   // [15:0] raw_count, [39:16] speed_target
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [47:0]               m_tdata,   // [31:0] drive, [47:32] speed
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]          cfg_data
);

	logic signed [15:0] gain_prop_q, gain_integ_q, gain_deriv_q;
	logic               err_valid, err_ready, prod_valid, prod_ready;
	epid_err_t          err_item;
	epid_prod_t         prod_item;
	logic signed [31:0] drive;
	logic signed [15:0] speed;

	assign cfg_ready = 1'b1;

	// Gain registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q  <= GAIN_PROP_RST;
			gain_integ_q <= GAIN_INTEG_RST;
			gain_deriv_q <= GAIN_DERIV_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAIN_PROP: begin
					gain_prop_q <= cfg_data;
				end
				REG_GAIN_INTEG: begin
					gain_integ_q <= cfg_data;
				end
				REG_GAIN_DERIV: begin
					gain_deriv_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	epid_speed #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_speed (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.raw_count   (s_tdata[15:0]),
		.speed_target($signed(s_tdata[39:16])),
		.out_valid   (err_valid),
		.out_ready   (err_ready),
		.out_item    (err_item)
	);

	epid_mult u_mult (
		.clk       (clk),
		.arst_n    (arst_n),
		.gain_prop (gain_prop_q),
		.gain_integ(gain_integ_q),
		.gain_deriv(gain_deriv_q),
		.in_valid  (err_valid),
		.in_ready  (err_ready),
		.in_item   (err_item),
		.out_valid (prod_valid),
		.out_ready (prod_ready),
		.out_item  (prod_item)
	);

	epid_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (prod_valid),
		.in_ready (prod_ready),
		.in_item  (prod_item),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.drive    (drive),
		.speed    (speed)
	);

	assign m_tdata = {speed, drive};

endmodule

`default_nettype wire

[dv/tb_encoder_speed_pid_unit.sv]
`timescale 1ns / 1ps
// Self-checking bench for encoder_speed_pid_unit: quadrature counter extension,
// speed, and the saturated P/I/D drive. It predicts every item in a scoreboard class.
// Depends on epid_pkg and the RTL under rtl/; reads no files.

module tb_encoder_speed_pid_unit;
	import epid_pkg::*;

	localparam int  HALF_RANGE  = 32768;
	localparam int  STALL_LIMIT = 3000;
	localparam int  BATCHES     = 6;
	localparam int  BATCH_ITEMS = 250;
	// No register sits behind this index; a write to it must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic signed [15:0] speed;
		logic signed [31:0] drive;
	} drive_word_t;

	// Predicts drive and speed per sample and holds the results still due
	class pid_drive_board;
		longint      kp, ki, kd;
		logic [15:0] prev_raw;
		logic [31:0] wraps;
		logic [47:0] prev_pos;
		longint      integ, prev_err;
		drive_word_t due[$];
		int          bad_fields;

		function new();
			kp = GAIN_PROP_RST;
			ki = GAIN_INTEG_RST;
			kd = GAIN_DERIV_RST;
			prev_raw = '0;
			wraps = '0;
			prev_pos = '0;
			integ = 0;
			prev_err = 0;
			bad_fields = 0;
		endfunction

		function void set_gain(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
			logic signed [15:0] g;
			g = val;
			case (idx)
			REG_GAIN_PROP: kp = g;
			REG_GAIN_INTEG: ki = g;
			REG_GAIN_DERIV: kd = g;
			default: ;
			endcase
		endfunction

		function longint clamp_word(longint x);
			if (x > 64'sd2147483647) begin
				return 64'sd2147483647;
			end else if (x < -64'sd2147483648) begin
				return -64'sd2147483648;
			end
			return x;
		endfunction

		// Extend the counter, derive speed and error, advance the integrator
		function void take_sample(logic [15:0] raw, logic [23:0] tgt);
			longint             jump, spd, err, p, d;
			logic signed [23:0] tgt_s;
			logic signed [47:0] moved;
			logic [47:0]        pos;
			drive_word_t        w;
			jump = longint'(raw) - longint'(prev_raw);
			if (jump >= HALF_RANGE) begin
				wraps = wraps - 1;
			end else if (jump <= -HALF_RANGE) begin
				wraps = wraps + 1;
			end
			pos = {wraps, raw};
			moved = pos - prev_pos;
			spd = moved;
			tgt_s = tgt;
			err = clamp_word(longint'(tgt_s) - spd * 256);
			p = (kp * err) >>> 8;
			integ = clamp_word(integ + ((ki * err) >>> 8));
			d = (kd * (err - prev_err)) >>> 8;
			w.drive = 32'(clamp_word(p + integ + d));
			// Reported speed clips at the field; a counter drop of exactly half the range reads 32767
			if (spd > 32767) begin
				w.speed = 16'sh7FFF;
			end else if (spd < -32768) begin
				w.speed = 16'sh8000;
			end else begin
				w.speed = 16'(spd);
			end
			prev_raw = raw;
			prev_pos = pos;
			prev_err = err;
			due.push_back(w);
		endfunction

		function void report(string msg);
			bad_fields++;
			if (bad_fields <= 10) begin
				$display("%0t mismatch: %s", $realtime, msg);
			end
		endfunction

		// Compare one output item with the oldest prediction
		function void check_drive(logic [47:0] data);
			drive_word_t want, got;
			got = data;
			if (due.size() == 0) begin
				report($sformatf("item with nothing due, drive %0d speed %0d",
					got.drive, got.speed));
				return;
			end
			want = due.pop_front();
			if (got.drive !== want.drive) begin
				report($sformatf("drive expected %0d, got %0d", want.drive, got.drive));
			end
			if (got.speed !== want.speed) begin
				report($sformatf("speed expected %0d, got %0d", want.speed, got.speed));
			end
		endfunction

		function int pending();
			return due.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [39:0]          s_tdata;   // [15:0] raw_count, [39:16] speed_target
	logic                 m_tvalid;
	logic                 m_tready;
	logic [47:0]          m_tdata;   // [31:0] drive, [47:32] speed
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_data;

	int          src_idle_pct;
	int          snk_idle_pct;
	logic [15:0] cur_raw;
	int          stall;

	pid_drive_board board = new();

	encoder_speed_pid_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Throttle the output side at random
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// Note every handshake at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				board.set_gain(cfg_index, cfg_data);
			end
			if (s_tvalid && s_tready) begin
				board.take_sample(s_tdata[15:0], s_tdata[39:16]);
			end
			if (m_tvalid && m_tready) begin
				board.check_drive(m_tdata);
			end
		end
	end

	// End the run when nothing moves for too long
	initial begin
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
					|| (cfg_valid && cfg_ready)) begin
				stall = 0;
			end else begin
				stall++;
			end
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Offer one sample; called and returning at a falling edge
	task automatic send_sample(input logic [15:0] raw, input logic [23:0] tgt);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {tgt, raw};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (board.pending() != 0);
		@(negedge clk);
	endtask

	// Mostly plausible motion, with wraps, exact half-range steps and noise
	function automatic logic [15:0] next_raw();
		int pick;
		int step;
		pick = $urandom_range(99);
		if (pick < 60) begin
			step = int'($urandom_range(600)) - 300;
		end else if (pick < 80) begin
			step = int'($urandom_range(65534)) - 32767;
		end else if (pick < 90) begin
			case ($urandom_range(3))
			0: step = HALF_RANGE;
			1: step = -HALF_RANGE;
			2: step = HALF_RANGE - 1;
			default: step = 1 - HALF_RANGE;
			endcase
		end else begin
			step = int'($urandom_range(65535));
		end
		cur_raw = cur_raw + 16'(step);
		return cur_raw;
	endfunction

	function automatic logic [23:0] pick_target();
		int pick;
		pick = $urandom_range(99);
		if (pick < 40) begin
			return 24'(int'($urandom_range(8191)) - 4096);
		end else if (pick < 50) begin
			return 24'h7FFFFF;
		end else if (pick < 60) begin
			return 24'h800000;
		end
		return 24'($urandom);
	endfunction

	initial begin
		logic [15:0] dir_raw[14];
		logic [23:0] dir_tgt[14];
		int          b;
		dir_raw = '{16'd0, 16'd100, 16'd65535, 16'd0, 16'd32768, 16'd0, 16'd32767,
			16'd65535, 16'd32767, 16'd32767, 16'hAAAA, 16'h5555, 16'hFFFF, 16'd0};
		dir_tgt = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'h000000, 24'h000000,
			24'hFFFFFF, 24'h123456, 24'h800000, 24'h7FFFFF, 24'h000000, 24'h555555,
			24'hAAAAAA, 24'h7FFFFF, 24'h800000};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_GAIN_PROP;
		cfg_data = '0;
		cur_raw = '0;
		src_idle_pct = 8;
		snk_idle_pct = 76;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: counter extremes, wraps both ways, exact half-range jumps,
		// setpoint extremes, all under the reset gains
		for (int i = 0; i < 14; i++) begin
			send_sample(dir_raw[i], dir_tgt[i]);
		end
		s_tvalid <= 1'b0;
		cur_raw = dir_raw[13];

		// Random batches, each under its own gain setting; idle mixes are shared in pairs
		for (b = 0; b < BATCHES; b++) begin
			wait_drained();
			src_idle_pct = (b < 2) ? 8 : (b < 4) ? 76 : 0;
			snk_idle_pct = (b < 2) ? 76 : (b < 4) ? 8 : 0;
			case (b)
			0: begin
				write_gain(REG_GAIN_PROP, 16'h8000);
				write_gain(REG_GAIN_INTEG, 16'h7FFF);
				write_gain(REG_GAIN_DERIV, 16'h8000);
				write_gain(REG_SPARE, 16'($urandom));
			end
			1: begin
				write_gain(REG_GAIN_PROP, 16'h7FFF);
				write_gain(REG_GAIN_INTEG, 16'h8000);
				write_gain(REG_GAIN_DERIV, 16'h7FFF);
			end
			2: begin
				write_gain(REG_GAIN_PROP, 16'h0100);
				write_gain(REG_GAIN_INTEG, 16'h0010);
				write_gain(REG_GAIN_DERIV, 16'h0080);
			end
			3: begin
				write_gain(REG_GAIN_PROP, 16'($urandom));
				write_gain(REG_GAIN_INTEG, 16'($urandom));
				write_gain(REG_GAIN_DERIV, 16'($urandom));
			end
			4: begin
				write_gain(REG_GAIN_PROP, 16'h0000);
				write_gain(REG_GAIN_INTEG, 16'h0000);
				write_gain(REG_GAIN_DERIV, 16'h0000);
			end
			default: begin
				write_gain(REG_GAIN_PROP, 16'(int'($urandom_range(2047)) - 1024));
				write_gain(REG_GAIN_INTEG, 16'(int'($urandom_range(2047)) - 1024));
				write_gain(REG_GAIN_DERIV, 16'(int'($urandom_range(2047)) - 1024));
			end
			endcase
			cfg_valid <= 1'b0;
			repeat (BATCH_ITEMS) begin
				send_sample(next_raw(), pick_target());
			end
			s_tvalid <= 1'b0;
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (board.bad_fields == 0 && board.pending() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/epid_pkg.sv
rtl/epid_speed.sv
rtl/epid_mult.sv
rtl/epid_accum.sv
rtl/encoder_speed_pid_unit.sv
dv/tb_encoder_speed_pid_unit.sv
